### rtl/pcb_pkg.sv
// Package with the shared types, codes and constants of the pixel compose buffer.
package pcb_pkg;

    localparam int STORE_WIDTH_DEF = 320;
    localparam int STORE_ROWS_DEF  = 64;
    localparam int CMD_FIFO_DEPTH  = 4;

    localparam int COORD_W    = 9;
    localparam int PIXEL_W    = 16;
    localparam int BITMAP_W   = 32;
    localparam int REQ_TYPE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CLIP_W_W   = 9;
    localparam int CLIP_H_W   = 7;
    localparam int GLYPH_W_W  = 6;
    localparam int ADDR_MAX_W = 18;

    localparam logic [REQ_TYPE_W-1:0] REQ_FILL  = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_GLYPH = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_IMAGE = 2'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH = 2'd2;

    localparam logic [CLIP_W_W-1:0]  CLIP_WIDTH_RST  = 9'd320;
    localparam logic [CLIP_H_W-1:0]  CLIP_HEIGHT_RST = 7'd64;
    localparam logic [GLYPH_W_W-1:0] GLYPH_WIDTH_RST = 6'd16;
    localparam logic [GLYPH_W_W-1:0] GLYPH_WIDTH_MAX = 6'd32;

    typedef struct packed {
        logic                  is_read;
        logic                  glyph;
        logic                  transp;
        logic                  bad;
        logic [COORD_W-1:0]    x;
        logic [COORD_W-1:0]    x_end;
        logic [COORD_W-1:0]    y;
        logic [COORD_W-1:0]    y_end;
        logic [ADDR_MAX_W-1:0] addr;
        logic [BITMAP_W-1:0]   bits;
        logic [PIXEL_W-1:0]    fg;
        logic [PIXEL_W-1:0]    bg;
    } pcb_cmd_t;

endpackage

### rtl/pcb_if.sv
// Request and response channel interfaces of the pixel compose buffer.
interface pcb_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [8:0]  x;
    logic [8:0]  y;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [31:0] bitmap;
    logic [15:0] colour;
    logic [15:0] background;
    logic        transparent;

    modport source (
        output valid, req_type, x, y, w, h, bitmap, colour, background, transparent,
        input  ready
    );
    modport sink (
        input  valid, req_type, x, y, w, h, bitmap, colour, background, transparent,
        output ready
    );
endinterface

interface pcb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        out_of_range;

    modport source (
        output valid, pixel, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, pixel, out_of_range,
        output ready
    );
endinterface

### rtl/pcb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module pcb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### rtl/pcb_front.sv
// Front end: configuration registers, request intake, clipping and command build.
module pcb_front #(
    parameter int STORE_WIDTH = pcb_pkg::STORE_WIDTH_DEF,
    parameter int STORE_ROWS  = pcb_pkg::STORE_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pcb_req_if.sink                       req,
    input  logic                          fifo_full,
    output logic                          push,
    output pcb_pkg::pcb_cmd_t             cmd
);
    import pcb_pkg::*;

    localparam int AW = $clog2(STORE_WIDTH * STORE_ROWS);

    logic [CLIP_W_W-1:0]  clip_width_reg;
    logic [CLIP_H_W-1:0]  clip_height_reg;
    logic [GLYPH_W_W-1:0] glyph_width_reg;

    logic [COORD_W-1:0] cw;
    logic [COORD_W:0]   ch;
    logic [GLYPH_W_W-1:0] gw;
    logic [COORD_W:0]   fill_xe;
    logic [COORD_W:0]   fill_ye;
    logic [COORD_W:0]   glyph_xe;
    logic [COORD_W-1:0] xe_clip;
    logic [COORD_W-1:0] ye_clip;
    logic [COORD_W-1:0] gxe_clip;
    logic               in_clip;
    logic               effective;
    logic [31:0]        start_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg  <= CLIP_WIDTH_RST;
            clip_height_reg <= CLIP_HEIGHT_RST;
            glyph_width_reg <= GLYPH_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLIP_WIDTH:  clip_width_reg  <= cfg_wdata[CLIP_W_W-1:0];
                REG_CLIP_HEIGHT: clip_height_reg <= cfg_wdata[CLIP_H_W-1:0];
                REG_GLYPH_WIDTH: glyph_width_reg <= cfg_wdata[GLYPH_W_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        cw = (clip_width_reg < CLIP_W_W'(STORE_WIDTH)) ? clip_width_reg
                                                       : CLIP_W_W'(STORE_WIDTH);
        ch = ((COORD_W+1)'(clip_height_reg) < (COORD_W+1)'(STORE_ROWS))
             ? (COORD_W+1)'(clip_height_reg) : (COORD_W+1)'(STORE_ROWS);
        gw = (glyph_width_reg > GLYPH_WIDTH_MAX) ? GLYPH_WIDTH_MAX : glyph_width_reg;

        fill_xe  = {1'b0, req.x} + {1'b0, req.w};
        fill_ye  = {1'b0, req.y} + {1'b0, req.h};
        glyph_xe = {1'b0, req.x} + (COORD_W+1)'(gw);
        xe_clip  = (fill_xe > {1'b0, cw}) ? cw : fill_xe[COORD_W-1:0];
        ye_clip  = (fill_ye > ch) ? ch[COORD_W-1:0] : fill_ye[COORD_W-1:0];
        gxe_clip = (glyph_xe > {1'b0, cw}) ? cw : glyph_xe[COORD_W-1:0];
        in_clip  = (req.x < cw) && ({1'b0, req.y} < ch);

        start_addr = 32'(req.y) * 32'(STORE_WIDTH) + 32'(req.x);

        cmd.is_read = 1'b0;
        cmd.glyph   = 1'b0;
        cmd.transp  = req.transparent;
        cmd.bad     = (req.w == '0) || (req.h == '0) || (req.x >= req.w) || (req.y >= req.h)
                      || (32'(req.x) >= 32'(STORE_WIDTH)) || (32'(req.y) >= 32'(STORE_ROWS));
        cmd.x       = req.x;
        cmd.x_end   = xe_clip;
        cmd.y       = req.y;
        cmd.y_end   = ye_clip;
        cmd.addr    = ADDR_MAX_W'(start_addr[AW-1:0]);
        cmd.bits    = req.bitmap;
        cmd.fg      = req.colour;
        cmd.bg      = req.background;
        effective   = 1'b0;

        unique case (req.req_type)
            REQ_FILL:
            begin
                effective = in_clip && (req.w != '0) && (req.h != '0);
            end
            REQ_GLYPH:
            begin
                cmd.glyph = 1'b1;
                cmd.x_end = gxe_clip;
                cmd.y_end = req.y + COORD_W'(1);
                effective = in_clip && (gw != '0);
            end
            REQ_IMAGE:
            begin
                cmd.x_end = req.x + COORD_W'(1);
                cmd.y_end = req.y + COORD_W'(1);
                cmd.fg    = {req.colour[4:0], req.colour[10:5], req.colour[15:11]};
                effective = in_clip;
            end
            REQ_READ:
            begin
                cmd.is_read = 1'b1;
                effective   = 1'b1;
            end
            default:
            begin
                effective = 1'b0;
            end
        endcase
    end

    assign req.ready = !fifo_full;
    assign push      = req.valid && !fifo_full && effective;
endmodule

### rtl/pcb_cmd_fifo.sv
// Short command queue between the front end and the drawing engine.
module pcb_cmd_fifo #(
    parameter int DEPTH = pcb_pkg::CMD_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcb_pkg::pcb_cmd_t push_cmd,
    input  logic              pop,
    output pcb_pkg::pcb_cmd_t head_cmd,
    output logic              not_empty,
    output logic              full
);
    import pcb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcb_cmd_t         entries [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_cmd  = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full) else $error("Command pushed into a full queue.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH)) else $error("Queue count exceeds its depth.");
`endif
endmodule

### rtl/pcb_back.sv
// Drawing engine: walks pixel writes into the frame store and serves pixel reads.
module pcb_back #(
    parameter int STORE_WIDTH = pcb_pkg::STORE_WIDTH_DEF,
    parameter int STORE_ROWS  = pcb_pkg::STORE_ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcb_pkg::pcb_cmd_t cmd,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    pcb_rsp_if.source         rsp
);
    import pcb_pkg::*;

    localparam int DEPTH = STORE_WIDTH * STORE_ROWS;
    localparam int AW = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DRAW   = 2'd1;
    localparam logic [1:0] ST_RDWAIT = 2'd2;
    localparam logic [1:0] ST_RES    = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]  out_pixel_reg, out_pixel_next;
    logic                out_oor_reg, out_oor_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  x_start_reg, x_start_next;
    logic [COORD_W-1:0]  x_end_reg, x_end_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [COORD_W-1:0]  y_end_reg, y_end_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [AW-1:0]       row_base_reg, row_base_next;
    logic [BITMAP_W-1:0] bits_reg, bits_next;
    logic [PIXEL_W-1:0]  fg_reg, fg_next;
    logic [PIXEL_W-1:0]  bg_reg, bg_next;
    logic                glyph_reg, glyph_next;
    logic                transp_reg, transp_next;
    logic                bad_reg, bad_next;

    logic                ram_we;
    logic [PIXEL_W-1:0]  ram_wdata;
    logic                ram_re;
    logic [PIXEL_W-1:0]  ram_rdata;

    pcb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd.addr[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        out_oor_next   = out_oor_reg;
        col_next       = col_reg;
        x_start_next   = x_start_reg;
        x_end_next     = x_end_reg;
        row_next       = row_reg;
        y_end_next     = y_end_reg;
        addr_next      = addr_reg;
        row_base_next  = row_base_reg;
        bits_next      = bits_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        glyph_next     = glyph_reg;
        transp_next    = transp_reg;
        bad_next       = bad_reg;
        cmd_pop        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wdata      = (!glyph_reg || bits_reg[BITMAP_W-1]) ? fg_reg : bg_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    col_next      = cmd.x;
                    x_start_next  = cmd.x;
                    x_end_next    = cmd.x_end;
                    row_next      = cmd.y;
                    y_end_next    = cmd.y_end;
                    addr_next     = cmd.addr[AW-1:0];
                    row_base_next = cmd.addr[AW-1:0];
                    bits_next     = cmd.bits;
                    fg_next       = cmd.fg;
                    bg_next       = cmd.bg;
                    glyph_next    = cmd.glyph;
                    transp_next   = cmd.transp;
                    bad_next      = cmd.bad;
                    if (cmd.is_read)
                    begin
                        ram_re     = !cmd.bad;
                        state_next = ST_RDWAIT;
                    end
                    else
                    begin
                        state_next = ST_DRAW;
                    end
                end
            end
            ST_DRAW:
            begin
                ram_we = !glyph_reg || bits_reg[BITMAP_W-1] || !transp_reg;
                if (col_reg + COORD_W'(1) == x_end_reg)
                begin
                    if (row_reg + COORD_W'(1) == y_end_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next      = row_reg + COORD_W'(1);
                        col_next      = x_start_reg;
                        row_base_next = row_base_reg + AW'(STORE_WIDTH);
                        addr_next     = row_base_reg + AW'(STORE_WIDTH);
                    end
                end
                else
                begin
                    col_next  = col_reg + COORD_W'(1);
                    addr_next = addr_reg + AW'(1);
                    bits_next = {bits_reg[BITMAP_W-2:0], 1'b0};
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pixel_next = bad_reg ? '0 : ram_rdata;
                    out_oor_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pixel_reg <= out_pixel_next;
        out_oor_reg   <= out_oor_next;
        col_reg       <= col_next;
        x_start_reg   <= x_start_next;
        x_end_reg     <= x_end_next;
        row_reg       <= row_next;
        y_end_reg     <= y_end_next;
        addr_reg      <= addr_next;
        row_base_reg  <= row_base_next;
        bits_reg      <= bits_next;
        fg_reg        <= fg_next;
        bg_reg        <= bg_next;
        glyph_reg     <= glyph_next;
        transp_reg    <= transp_next;
        bad_reg       <= bad_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.pixel        = out_pixel_reg;
    assign rsp.out_of_range = out_oor_reg;

`ifndef SYNTHESIS
    a_write_only_drawing: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_DRAW) else $error("Store written outside a draw.");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == ST_IDLE) else $error("Command taken while busy.");
    a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAW |-> col_reg < x_end_reg)
        else $error("Draw column ran past the span end.");
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RES && (!out_valid_reg || rsp.ready)) |=> out_valid_reg)
        else $error("Read result was not presented.");
`endif
endmodule

### rtl/pixel_compose_buffer.sv
// Top level of the pixel compose buffer: RGB565 frame store with a drawing command engine.
// The req channel takes one drawing command per item: rectangle fill, glyph row,
// image pixel or pixel read. Only a pixel read produces an item on the rsp channel,
// carrying the pixel and an out-of-range flag. The cfg port writes the clip width,
// clip height and glyph width registers.
// The front end accepts a command and queues it in a four-entry queue; commands that
// draw nothing are dropped by the front end. The drawing engine handles one pixel per
// cycle and writes it through the single write port of the frame store, except a clear
// bit of a transparent glyph. It takes a command in its idle state and then steps through
// its pixels: a glyph row of up to 32 pixels, one image pixel or a fill row by row.
// A read passes the read-wait and result states; the result state loads its item into
// the output register. Reset clears the queue and the result valid flag and restores
// the register reset values; the frame store content stays undefined until written.
// When the receiver stalls, the result stays in its output register; a following
// read waits in the engine until it is taken, which holds back the commands behind
// it, and the req channel stalls once the queue is full.
module pixel_compose_buffer #(
    parameter int STORE_WIDTH = pcb_pkg::STORE_WIDTH_DEF,
    parameter int STORE_ROWS  = pcb_pkg::STORE_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pcb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pcb_req_if.sink                       req,
    pcb_rsp_if.source                     rsp
);
    import pcb_pkg::*;

    pcb_cmd_t push_cmd;
    pcb_cmd_t head_cmd;
    logic     push;
    logic     pop;
    logic     not_empty;
    logic     full;

    pcb_front #(
        .STORE_WIDTH (STORE_WIDTH),
        .STORE_ROWS  (STORE_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .fifo_full (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    pcb_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .not_empty (not_empty),
        .full      (full)
    );

    pcb_back #(
        .STORE_WIDTH (STORE_WIDTH),
        .STORE_ROWS  (STORE_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_valid (not_empty),
        .cmd_pop   (pop),
        .rsp       (rsp)
    );
endmodule
